// File: src/bpvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpvd_pkg: shared types and constants
// Field widths, register indexes, reset values and pipeline control types
// for the balance drive controller.
// ---------------------------------------------------------------------------
package bpvd_pkg;

	localparam int NSTAGE    = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ROLL_SETPOINT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KD       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_CUTOFF    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd7;

	localparam logic [15:0] TILT_CUTOFF_RST    = 16'd10240;
	localparam logic [14:0] INTEGRAL_LIMIT_RST = 15'd1000;
	localparam logic [12:0] DRIVE_LIMIT_RST    = 13'd6900;

	// low-pass coefficients, Q.8
	localparam logic signed [22:0] ALPHA_NUM  = 23'sd77;
	localparam logic signed [33:0] ALPHA_REST = 34'sd179;

	typedef struct packed {
		logic signed [16:0] roll_setpoint;
		logic signed [15:0] angle_kp;
		logic signed [15:0] angle_kd;
		logic signed [15:0] speed_kp;
		logic signed [15:0] speed_ki;
		logic [15:0]        tilt_cutoff;
		logic [14:0]        integral_limit;
		logic [12:0]        drive_limit;
	} cfg_t;

	typedef struct packed {
		logic [NSTAGE-1:0] load;
		logic [NSTAGE-1:0] valid;
	} stage_ctl_t;

endpackage
`default_nettype wire

// File: src/bpvd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpvd_cfg: configuration register file
// Holds gains, setpoint, cutoff and limits; written one register per transaction.
// ---------------------------------------------------------------------------
module bpvd_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [bpvd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpvd_pkg::CFG_DAT_W-1:0]  cfg_data,
	output bpvd_pkg::cfg_t                       cfg
);

	bpvd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_setpoint  <= '0;
			cfg_q.angle_kp       <= '0;
			cfg_q.angle_kd       <= '0;
			cfg_q.speed_kp       <= '0;
			cfg_q.speed_ki       <= '0;
			cfg_q.tilt_cutoff    <= bpvd_pkg::TILT_CUTOFF_RST;
			cfg_q.integral_limit <= bpvd_pkg::INTEGRAL_LIMIT_RST;
			cfg_q.drive_limit    <= bpvd_pkg::DRIVE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bpvd_pkg::REG_ROLL_SETPOINT:  cfg_q.roll_setpoint  <= $signed(cfg_data);
				bpvd_pkg::REG_ANGLE_KP:       cfg_q.angle_kp       <= $signed(cfg_data[15:0]);
				bpvd_pkg::REG_ANGLE_KD:       cfg_q.angle_kd       <= $signed(cfg_data[15:0]);
				bpvd_pkg::REG_SPEED_KP:       cfg_q.speed_kp       <= $signed(cfg_data[15:0]);
				bpvd_pkg::REG_SPEED_KI:       cfg_q.speed_ki       <= $signed(cfg_data[15:0]);
				bpvd_pkg::REG_TILT_CUTOFF:    cfg_q.tilt_cutoff    <= cfg_data[15:0];
				bpvd_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[14:0];
				bpvd_pkg::REG_DRIVE_LIMIT:    cfg_q.drive_limit    <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: src/bpvd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpvd_ctrl: pipeline flow control
// Tracks one valid bit per stage and lets bubbles collapse, so a stage loads
// whenever it is empty or its occupant moves on.
// ---------------------------------------------------------------------------
module bpvd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bpvd_pkg::stage_ctl_t   ctl
);

	logic [bpvd_pkg::NSTAGE-1:0] valid_q;
	logic [bpvd_pkg::NSTAGE-1:0] rdy;
	logic [bpvd_pkg::NSTAGE-1:0] drain;
	logic [bpvd_pkg::NSTAGE-1:0] load;

	always_comb begin
		drain[bpvd_pkg::NSTAGE-1] = out_ready;
		rdy[bpvd_pkg::NSTAGE-1]   = !valid_q[bpvd_pkg::NSTAGE-1] || out_ready;
		for (int k = bpvd_pkg::NSTAGE - 2; k >= 0; k--) begin
			drain[k] = rdy[k+1];
			rdy[k]   = !valid_q[k] || rdy[k+1];
		end
		load[0] = in_valid && rdy[0];
		for (int k = 1; k < bpvd_pkg::NSTAGE; k++) begin
			load[k] = valid_q[k-1] && rdy[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < bpvd_pkg::NSTAGE; k++) begin
				if (load[k]) begin
					valid_q[k] <= 1'b1;
				end else if (drain[k]) begin
					valid_q[k] <= 1'b0;
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = valid_q[bpvd_pkg::NSTAGE-1];
	assign ctl.load  = load;
	assign ctl.valid = valid_q;

endmodule
`default_nettype wire

// File: src/bpvd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpvd_datapath: PD/PI arithmetic pipeline
// Stage 1 registers the tick, stage 2 forms the angle error and updates the
// speed filter, stage 3 updates the integral and forms the gain products,
// stage 4 sums them and forms the integral-gain product, stage 5 scales and saturates the drive.
// ---------------------------------------------------------------------------
module bpvd_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bpvd_pkg::cfg_t       cfg,
	input  wire bpvd_pkg::stage_ctl_t ctl,
	input  wire logic signed [16:0]   roll_angle,
	input  wire logic signed [15:0]   left_speed,
	input  wire logic signed [15:0]   right_speed,
	output logic signed [13:0]        drive,
	output logic                      tilt_cut
);

	// loop state
	logic signed [17:0] prev_err_q;
	logic signed [25:0] fs_q;
	logic signed [15:0] integ_q;

	// stage registers
	logic signed [16:0] roll_s1;
	logic signed [15:0] left_s1, right_s1;
	logic signed [17:0] err_s2;
	logic signed [18:0] diff_s2;
	logic signed [25:0] fs_s2;
	logic               cut_s2;
	logic signed [33:0] p_ap_s3;
	logic signed [34:0] p_ad_s3;
	logic signed [41:0] p_sp_s3;
	logic signed [15:0] integ_s3;
	logic               cut_s3;
	logic signed [44:0] psum_s4;
	logic signed [31:0] p_int_s4;
	logic               cut_s4;
	logic signed [13:0] drive_s5;
	logic               cut_s5;

	// stage 2 logic
	logic signed [17:0] roll_x, mag_c, err_c;
	logic signed [18:0] diff_c;
	logic               cut_c;
	logic signed [16:0] sum_c, sum_adj;
	logic signed [15:0] avg_c;
	logic signed [22:0] mul77_c;
	logic signed [33:0] mul179_c;
	logic signed [25:0] fs_next;

	// stage 3 logic
	logic signed [18:0] integ_sum, ilim;
	logic signed [15:0] integ_next;

	// stage 5 logic
	logic signed [45:0] acc_c;
	logic signed [29:0] scaled_c, dlim;
	logic signed [13:0] drive_c;

	always_comb begin
		roll_x  = 18'(roll_s1);
		mag_c   = roll_x[17] ? -roll_x : roll_x;
		cut_c   = mag_c > $signed({2'b00, cfg.tilt_cutoff});
		err_c   = 18'(cfg.roll_setpoint) - roll_x;
		diff_c  = 19'(err_c) - 19'(prev_err_q);
		// mean speed, truncated toward zero
		sum_c   = 17'(left_s1) + 17'(right_s1);
		sum_adj = sum_c[16] ? sum_c + 17'sd1 : sum_c;
		avg_c   = 16'(sum_adj >>> 1);
		mul77_c  = 23'(avg_c) * bpvd_pkg::ALPHA_NUM;
		mul179_c = 34'(fs_q) * bpvd_pkg::ALPHA_REST;
		fs_next  = 26'(mul77_c) + 26'(mul179_c >>> 8);
	end

	always_comb begin
		integ_sum = 19'(integ_q) + 19'(fs_s2 >>> 8);
		ilim      = $signed({4'b0000, cfg.integral_limit});
		if (integ_sum > ilim) begin
			integ_next = 16'(ilim);
		end else if (integ_sum < -ilim) begin
			integ_next = 16'(-ilim);
		end else begin
			integ_next = 16'(integ_sum);
		end
	end

	always_comb begin
		acc_c    = 46'(psum_s4) + (46'(p_int_s4) <<< 8);
		scaled_c = 30'(acc_c >>> 16);
		dlim     = $signed({17'd0, cfg.drive_limit});
		if (scaled_c > dlim) begin
			drive_c = 14'(dlim);
		end else if (scaled_c < -dlim) begin
			drive_c = 14'(-dlim);
		end else begin
			drive_c = 14'(scaled_c);
		end
	end

	// loop state advances as each transaction passes its stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			fs_q       <= '0;
			integ_q    <= '0;
		end else begin
			if (ctl.load[1]) begin
				prev_err_q <= err_c;
				fs_q       <= fs_next;
			end
			if (ctl.load[2]) begin
				integ_q <= integ_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			roll_s1  <= roll_angle;
			left_s1  <= left_speed;
			right_s1 <= right_speed;
		end
		if (ctl.load[1]) begin
			err_s2  <= err_c;
			diff_s2 <= diff_c;
			fs_s2   <= fs_next;
			cut_s2  <= cut_c;
		end
		if (ctl.load[2]) begin
			// drop the angle term when tilted past the cutoff
			p_ap_s3  <= cut_s2 ? '0 : 34'(cfg.angle_kp) * 34'(err_s2);
			p_ad_s3  <= cut_s2 ? '0 : 35'(cfg.angle_kd) * 35'(diff_s2);
			p_sp_s3  <= 42'(cfg.speed_kp) * 42'(fs_s2);
			integ_s3 <= integ_next;
			cut_s3   <= cut_s2;
		end
		if (ctl.load[3]) begin
			psum_s4  <= 45'(p_ap_s3) + 45'(p_ad_s3) + 45'(p_sp_s3);
			p_int_s4 <= 32'(cfg.speed_ki) * 32'(integ_s3);
			cut_s4   <= cut_s3;
		end
		if (ctl.load[4]) begin
			drive_s5 <= drive_c;
			cut_s5   <= cut_s4;
		end
	end

	assign drive    = drive_s5;
	assign tilt_cut = cut_s5;

endmodule
`default_nettype wire

// File: src/balance_pd_velocity_pi_drive_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Five register stages lie between an accepted input transaction and out_valid.
// Throughput: one transaction per cycle unless out_ready stalls the output; the
// filter, integral and error state each close their loop inside a single stage.
// Bubbles collapse, so input is taken while a finished result waits.
// Reset clears stage valid bits and loop state and restores register defaults.
// ---------------------------------------------------------------------------
// balance_pd_velocity_pi_drive_top: cascaded angle PD / speed PI drive
// Forms the saturated motor drive from roll angle and wheel speeds per tick.
// ---------------------------------------------------------------------------
module balance_pd_velocity_pi_drive_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [16:0]              roll_angle,
	input  wire logic signed [15:0]              left_speed,
	input  wire logic signed [15:0]              right_speed,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [13:0]                   drive,
	output logic                                 tilt_cut,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bpvd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpvd_pkg::CFG_DAT_W-1:0]  cfg_data
);

	bpvd_pkg::cfg_t       cfg;
	bpvd_pkg::stage_ctl_t ctl;

	assign cfg_ready = 1'b1;

	bpvd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	bpvd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.ctl         (ctl),
		.roll_angle  (roll_angle),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.drive       (drive),
		.tilt_cut    (tilt_cut)
	);

	// input stalls only when every stage holds a transaction and output is blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&ctl.valid) && !out_ready)
		else $error("input stalled with a free stage");

	// a result leaving the last stage empties it when the stage before holds none
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !ctl.valid[bpvd_pkg::NSTAGE-2] |=> !out_valid)
		else $error("output stage kept a delivered result");

	// delivered drive stays within the drive limit
	a_drive_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive <= $signed({1'b0, cfg.drive_limit}))
			&& (drive >= -$signed({1'b0, cfg.drive_limit})))
		else $error("drive beyond limit");

endmodule
`default_nettype wire

// File: verif/balance_pd_velocity_pi_drive_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// balance_pd_velocity_pi_drive_top_tb: self-checking bench for the drive
// Sends control ticks through the valid/ready input channel and checks every
// drive result against a cycle-free model of the angle PD / speed PI loop.
// The model's copy of the registers follows the writes seen on the config
// channel. Both sides idle at random, and two long receiver hold-offs back
// the pipeline up into the input.
// ---------------------------------------------------------------------------

typedef struct packed {
	logic signed [13:0] drive;
	logic               tilt_cut;
} drive_result_t;

class drive_scoreboard;
	bpvd_pkg::cfg_t     regs;
	logic signed [17:0] last_error;
	logic signed [25:0] speed_lp;
	logic signed [15:0] speed_integral;
	drive_result_t      expected_drives[$];
	int                 ticks;
	int                 checked;
	int                 cut_ticks;
	int                 clamped;
	int                 mismatches;

	function new();
		regs                = '0;
		regs.tilt_cutoff    = bpvd_pkg::TILT_CUTOFF_RST;
		regs.integral_limit = bpvd_pkg::INTEGRAL_LIMIT_RST;
		regs.drive_limit    = bpvd_pkg::DRIVE_LIMIT_RST;
		last_error          = '0;
		speed_lp            = '0;
		speed_integral      = '0;
	endfunction

	function void apply_write(logic [bpvd_pkg::CFG_IDX_W-1:0] idx,
			logic [bpvd_pkg::CFG_DAT_W-1:0] data);
		case (idx)
			bpvd_pkg::REG_ROLL_SETPOINT:  regs.roll_setpoint  = data[16:0];
			bpvd_pkg::REG_ANGLE_KP:       regs.angle_kp       = data[15:0];
			bpvd_pkg::REG_ANGLE_KD:       regs.angle_kd       = data[15:0];
			bpvd_pkg::REG_SPEED_KP:       regs.speed_kp       = data[15:0];
			bpvd_pkg::REG_SPEED_KI:       regs.speed_ki       = data[15:0];
			bpvd_pkg::REG_TILT_CUTOFF:    regs.tilt_cutoff    = data[15:0];
			bpvd_pkg::REG_INTEGRAL_LIMIT: regs.integral_limit = data[14:0];
			bpvd_pkg::REG_DRIVE_LIMIT:    regs.drive_limit    = data[12:0];
			default: ;
		endcase
	endfunction

	function void predict_tick(logic signed [16:0] roll, logic signed [15:0] lspd,
			logic signed [15:0] rspd);
		longint        roll_v, mag, err, delta, avg, lp, integ, lim, acc, drv;
		bit            cut;
		drive_result_t want;
		roll_v = longint'(roll);
		mag    = roll_v < 0 ? -roll_v : roll_v;
		cut    = mag > longint'(regs.tilt_cutoff);

		err        = longint'($signed(regs.roll_setpoint)) - roll_v;
		delta      = err - longint'(last_error);
		last_error = err[17:0];

		// integer division truncates toward zero, as the mean requires
		avg      = (longint'(lspd) + longint'(rspd)) / 2;
		lp       = longint'(bpvd_pkg::ALPHA_NUM) * avg
			+ ((longint'(bpvd_pkg::ALPHA_REST) * longint'(speed_lp)) >>> 8);
		speed_lp = lp[25:0];

		lim   = longint'(regs.integral_limit);
		integ = longint'(speed_integral) + (lp >>> 8);
		if (integ > lim) integ = lim;
		if (integ < -lim) integ = -lim;
		speed_integral = integ[15:0];

		acc = longint'($signed(regs.speed_kp)) * lp
			+ longint'($signed(regs.speed_ki)) * integ * 256;
		if (!cut)
			acc += longint'($signed(regs.angle_kp)) * err
				+ longint'($signed(regs.angle_kd)) * delta;

		lim = longint'(regs.drive_limit);
		drv = acc >>> 16;
		if (drv > lim || drv < -lim) clamped++;
		if (drv > lim) drv = lim;
		if (drv < -lim) drv = -lim;

		want.drive    = drv[13:0];
		want.tilt_cut = cut;
		expected_drives.push_back(want);
		ticks++;
		if (cut) cut_ticks++;
	endfunction

	function void flag(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		else if (mismatches == 41)
			$display("%0t: further mismatches not shown", $time);
	endfunction

	function void check_drive(logic signed [13:0] got_drive, logic got_cut);
		drive_result_t want;
		if (expected_drives.size() == 0) begin
			flag("unexpected result, drive", 0, got_drive);
			return;
		end
		want = expected_drives.pop_front();
		checked++;
		if (want.drive !== got_drive)
			flag("drive", want.drive, got_drive);
		if (want.tilt_cut !== got_cut)
			flag("tilt_cut", want.tilt_cut, got_cut);
	endfunction

	function int pending();
		return expected_drives.size();
	endfunction
endclass

module balance_pd_velocity_pi_drive_top_tb;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [16:0]                roll_angle;
	logic signed [15:0]                left_speed;
	logic signed [15:0]                right_speed;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [13:0]                drive;
	logic                              tilt_cut;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [bpvd_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [bpvd_pkg::CFG_DAT_W-1:0]    cfg_data;

	drive_scoreboard sb;
	bpvd_pkg::cfg_t  cur_cfg;
	int              in_gap_max;
	int              out_stall_max;
	int              hold_off_cycles;
	int              cruise_speed;
	int              settings_applied;

	balance_pd_velocity_pi_drive_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.roll_angle (roll_angle),
		.left_speed (left_speed),
		.right_speed(right_speed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive      (drive),
		.tilt_cut   (tilt_cut),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.apply_write(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.predict_tick(roll_angle, left_speed, right_speed);
			if (out_valid && out_ready)
				sb.check_drive(drive, tilt_cut);
		end
	end

	// receiver: random stall per result, plus a long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_cycles != 0) begin
				out_ready = 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
			end
			stall = $urandom_range(0, out_stall_max);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("balance_pd_velocity_pi_drive_top test failed");
		$finish;
	end

	// leaves cfg_valid high so back-to-back writes need no gap
	task automatic write_reg(input logic [bpvd_pkg::CFG_IDX_W-1:0] idx,
			input logic [bpvd_pkg::CFG_DAT_W-1:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_setting(input bpvd_pkg::cfg_t c);
		logic [16:0] pad;
		pad = 17'($urandom);
		// unused upper data bits carry junk that the block must ignore
		write_reg(bpvd_pkg::REG_ROLL_SETPOINT, c.roll_setpoint);
		write_reg(bpvd_pkg::REG_ANGLE_KP, {pad[0], c.angle_kp});
		write_reg(bpvd_pkg::REG_ANGLE_KD, {pad[1], c.angle_kd});
		write_reg(bpvd_pkg::REG_SPEED_KP, {pad[2], c.speed_kp});
		write_reg(bpvd_pkg::REG_SPEED_KI, {pad[3], c.speed_ki});
		write_reg(bpvd_pkg::REG_TILT_CUTOFF, {pad[4], c.tilt_cutoff});
		write_reg(bpvd_pkg::REG_INTEGRAL_LIMIT, {pad[6:5], c.integral_limit});
		write_reg(bpvd_pkg::REG_DRIVE_LIMIT, {pad[10:7], c.drive_limit});
		cfg_valid = 1'b0;
		cur_cfg   = c;
		settings_applied++;
	endtask

	function automatic bpvd_pkg::cfg_t make_setting(input int kind);
		bpvd_pkg::cfg_t c;
		case (kind)
			0: begin
				c.roll_setpoint  = 17'(int'($urandom_range(0, 4096)) - 2048);
				c.angle_kp       = 16'(int'($urandom_range(0, 4096)) - 2048);
				c.angle_kd       = 16'(int'($urandom_range(0, 8192)) - 4096);
				c.speed_kp       = 16'(int'($urandom_range(0, 1024)) - 512);
				c.speed_ki       = 16'(int'($urandom_range(0, 512)) - 256);
				c.tilt_cutoff    = 16'($urandom_range(5000, 20000));
				c.integral_limit = 15'($urandom_range(200, 5000));
				c.drive_limit    = 13'($urandom_range(1000, 7199));
			end
			1: begin
				c.roll_setpoint  = 17'sd46080;
				c.angle_kp       = 16'sd32767;
				c.angle_kd       = 16'sd32767;
				c.speed_kp       = 16'sd32767;
				c.speed_ki       = 16'sd32767;
				c.tilt_cutoff    = 16'd46080;
				c.integral_limit = 15'd32767;
				c.drive_limit    = 13'd7199;
			end
			2: begin
				c.roll_setpoint  = -17'sd46080;
				c.angle_kp       = 16'sh8000;
				c.angle_kd       = 16'sh8000;
				c.speed_kp       = 16'sh8000;
				c.speed_ki       = 16'sh8000;
				c.tilt_cutoff    = '0;
				c.integral_limit = '0;
				c.drive_limit    = 13'd7199;
			end
			3: begin
				// any bit pattern, including values past the documented ranges
				c.roll_setpoint  = 17'($urandom);
				c.angle_kp       = 16'($urandom);
				c.angle_kd       = 16'($urandom);
				c.speed_kp       = 16'($urandom);
				c.speed_ki       = 16'($urandom);
				c.tilt_cutoff    = 16'($urandom);
				c.integral_limit = 15'($urandom);
				c.drive_limit    = 13'($urandom);
			end
			4: begin
				c.roll_setpoint  = 17'(int'($urandom_range(0, 92160)) - 46080);
				c.angle_kp       = 16'($urandom);
				c.angle_kd       = 16'($urandom);
				c.speed_kp       = 16'($urandom);
				c.speed_ki       = 16'($urandom);
				c.tilt_cutoff    = 16'($urandom_range(0, 46080));
				c.integral_limit = 15'($urandom_range(0, 32767));
				c.drive_limit    = 13'($urandom_range(0, 7199));
			end
			default: begin
				c.roll_setpoint  = 17'sd256;
				c.angle_kp       = 16'sh0300;
				c.angle_kd       = 16'sh0a00;
				c.speed_kp       = 16'sh0080;
				c.speed_ki       = 16'sh0020;
				c.tilt_cutoff    = 16'd10240;
				c.integral_limit = 15'd1000;
				c.drive_limit    = 13'd6900;
			end
		endcase
		return c;
	endfunction

	// valid stays high across back-to-back transactions
	task automatic send_tick(input logic signed [16:0] roll, input logic signed [15:0] lspd,
			input logic signed [15:0] rspd);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		roll_angle  = roll;
		left_speed  = lspd;
		right_speed = rspd;
		in_valid    = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_tick();
		int sel, roll_i, lspd_i, rspd_i;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			roll_i = $urandom;
		else if (sel < 30) begin
			// straddle the cutoff on either side
			roll_i = int'(cur_cfg.tilt_cutoff) + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1)) roll_i = -roll_i;
		end else
			roll_i = int'($urandom_range(0, 92160)) - 46080;
		if (sel % 4 == 0) begin
			lspd_i = $urandom;
			rspd_i = $urandom;
		end else begin
			lspd_i = cruise_speed + int'($urandom_range(0, 1000)) - 500;
			rspd_i = cruise_speed + int'($urandom_range(0, 1000)) - 500;
		end
		send_tick(roll_i[16:0], lspd_i[15:0], rspd_i[15:0]);
	endtask

	task automatic finish_burst();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		sb               = new();
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		roll_angle       = '0;
		left_speed       = '0;
		right_speed      = '0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_gap_max       = 4;
		out_stall_max    = 4;
		hold_off_cycles  = 0;
		cruise_speed     = 0;
		settings_applied = 0;
		cur_cfg             = '0;
		cur_cfg.tilt_cutoff = bpvd_pkg::TILT_CUTOFF_RST;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values: zero gains, so only the tilt flag and loop state move
		send_tick(17'sd10240, 16'sd0, 16'sd0);
		send_tick(17'sd10241, 16'sd500, 16'sd300);
		send_tick(-17'sd10241, 16'sd100, -16'sd50);
		finish_burst();

		apply_setting(make_setting(5));
		send_tick(17'sd0, 16'sd0, 16'sd0);
		send_tick(17'sd256, 16'sd0, 16'sd0);
		send_tick(17'sd46080, 16'sd32767, 16'sd32767);
		send_tick(-17'sd46080, 16'sh8000, 16'sh8000);
		send_tick(17'sd10240, 16'sd1000, 16'sd1000);
		send_tick(-17'sd10240, 16'sd1000, 16'sd999);
		send_tick(17'sd10241, -16'sd3, 16'sd0);
		send_tick(-17'sd10241, 16'sd3, 16'sd0);
		send_tick(17'sh10000, 16'sh8000, 16'sd32767);
		send_tick(17'sd65535, 16'sd32767, 16'sh8000);
		// run the integral into its clamp, then back the other way
		repeat (4) send_tick(17'sd0, 16'sd32767, 16'sd32767);
		repeat (3) send_tick(17'sd100, 16'sh8000, 16'sh8000);
		finish_burst();

		// zero limits hold the integral and the drive at zero
		write_reg(bpvd_pkg::REG_INTEGRAL_LIMIT, '0);
		write_reg(bpvd_pkg::REG_DRIVE_LIMIT, '0);
		cfg_valid = 1'b0;
		send_tick(17'sd0, 16'sd20000, 16'sd20000);
		send_tick(-17'sd20000, -16'sd20000, -16'sd20000);
		send_tick(17'sd20000, 16'sd5, -16'sd7);
		finish_burst();

		for (int p = 0; p < 8; p++) begin
			in_gap_max    = (p == 1 || p == 5) ? 0 : 4;
			out_stall_max = (p == 1 || p == 6) ? 0 : 4;
			apply_setting(make_setting(p % 5));
			// back the pipeline up into the input
			if (p == 2 || p == 5) hold_off_cycles = 80;
			for (int i = 0; i < 100; i++) begin
				if (i % 25 == 0) cruise_speed = int'($urandom_range(0, 60000)) - 30000;
				send_random_tick();
			end
			finish_burst();
		end

		repeat (10) @(negedge clk);
		$display("Covered %0d control ticks over %0d register settings, %0d with the tilt cut",
			sb.checked, settings_applied, sb.cut_ticks);
		$display("%0d drive values hit the drive limit, %0d mismatches",
			sb.clamped, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("balance_pd_velocity_pi_drive_top test passed");
		else
			$display("balance_pd_velocity_pi_drive_top test failed");
		$finish;
	end

endmodule

// File: filelist.f
src/bpvd_pkg.sv
src/bpvd_cfg.sv
src/bpvd_ctrl.sv
src/bpvd_datapath.sv
src/balance_pd_velocity_pi_drive_top.sv
verif/balance_pd_velocity_pi_drive_top_tb.sv
